[design/gsat_pkg.sv]
// Shared constants, widths and opcodes of the gait step asymmetry tracker.
package gsat_pkg;

    localparam int WINDOW_STEPS = 8;
    localparam int CALIB_STEPS  = 8;

    localparam int FORCE_W = 16;
    localparam int PCT_W   = 15;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_CALIB   = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN     = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam int ASYM_SCALE = 25600;

    localparam int POS_W   = (WINDOW_STEPS > 1) ? $clog2(WINDOW_STEPS) : 1;
    localparam int FILL_W  = $clog2(WINDOW_STEPS + 1);
    localparam int CCNT_W  = $clog2(CALIB_STEPS + 1);
    localparam int WSUM_W  = FORCE_W + FILL_W;
    localparam int CSUM_W  = FORCE_W + CCNT_W;
    localparam int RAM_DEPTH = 2 * WINDOW_STEPS;
    localparam int RAM_AW  = $clog2(RAM_DEPTH);

    localparam int PROD_W    = FORCE_W + $clog2(ASYM_SCALE);
    localparam int DIVD_RAW0 = (PROD_W > WSUM_W) ? PROD_W : WSUM_W;
    localparam int DIVD_RAW  = (DIVD_RAW0 > CSUM_W) ? DIVD_RAW0 : CSUM_W;
    localparam int DIVD_W    = DIVD_RAW + (DIVD_RAW % 2);
    localparam int DSOR_W    = FORCE_W;
    localparam int DIV_CYC   = DIVD_W / 2;
    localparam int CNT_W     = $clog2(DIV_CYC);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_MIN_FORCE    = 1'b0;
    localparam logic REG_ALERT_MARGIN = 1'b1;

    localparam logic [FORCE_W-1:0] MIN_FORCE_RST    = 16'd256;
    localparam logic [FORCE_W-1:0] ALERT_MARGIN_RST = 16'd2560;

endpackage

[design/gsat_if.sv]
// Step and result channel interfaces of the gait step asymmetry tracker.
interface gsat_in_if
    import gsat_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [FORCE_W-1:0] step_force;
    logic               is_left;

    modport source (output valid, opcode, step_force, is_left, input ready);
    modport sink   (input valid, opcode, step_force, is_left, output ready);
endinterface

interface gsat_out_if
    import gsat_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [FORCE_W-1:0] left_average;
    logic [FORCE_W-1:0] right_average;
    logic [PCT_W-1:0]   asymmetry_percent;
    logic [FORCE_W-1:0] alert_threshold;
    logic               calibration_done;

    modport source (
        output valid, left_average, right_average, asymmetry_percent,
               alert_threshold, calibration_done,
        input  ready
    );
    modport sink (
        input  valid, left_average, right_average, asymmetry_percent,
               alert_threshold, calibration_done,
        output ready
    );
endinterface

[design/gsat_ram.sv]
// Single-port RAM with registered read data.
module gsat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[design/gait_step_asymmetry_tracker.sv]
// Top level of the gait step asymmetry tracker.
//
// in_ch carries one step transaction (opcode, step_force, is_left); out_ch
// returns exactly one result transaction per step: both window means, their
// asymmetry percent, the alert threshold and the calibration flag. The APB
// port holds min_force at address 0 and alert_margin at address 4.
//
// One step is processed at a time. After acceptance a step goes through a
// window write when it is pushed, the calibration means on a step that
// refreshes the baseline, and each division the step needs, unless skipped
// (empty window, force below min_force). A running step needs the two window
// means and the asymmetry division; a calibration step that refreshes the
// baseline adds the calibration means and one more division. The shared
// radix-4 divider loads its operands, then forms two quotient bits per cycle.
// The next step is taken once the result is registered.
//
// Reset clears the session, the output slot and loads the register defaults;
// the window RAM needs no clearing since only filled entries are read.
// A finished result waits in the output register; the next step is taken
// while it waits, and its own result holds until the slot frees up.
module gait_step_asymmetry_tracker
    import gsat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    gsat_in_if.sink            in_ch,
    gsat_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WRITE = 9'b000000010,
        S_LCAL  = 9'b000000100,
        S_RCAL  = 9'b000001000,
        S_BASE  = 9'b000010000,
        S_LMEAN = 9'b000100000,
        S_RMEAN = 9'b001000000,
        S_ASYM  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [DSOR_W-1:0] rem;
        logic [DIVD_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic              skip;
        logic [DIVD_W-1:0] dividend;
        logic [DSOR_W-1:0] divisor;
    } div_op_t;

    function automatic div_t div_step(div_t d, logic [DSOR_W-1:0] dsor);
        logic [DSOR_W:0] trial;
        div_t            r;
        trial = {d.rem, d.quo[DIVD_W-1]};
        r.quo = {d.quo[DIVD_W-2:0], 1'b0};
        if (trial >= {1'b0, dsor})
        begin
            r.rem    = DSOR_W'(trial - {1'b0, dsor});
            r.quo[0] = 1'b1;
        end
        else
        begin
            r.rem = trial[DSOR_W-1:0];
        end
        return r;
    endfunction

    function automatic div_op_t asym_op(logic [FORCE_W-1:0] l, logic [FORCE_W-1:0] r,
                                        logic [FORCE_W-1:0] mn);
        logic [FORCE_W-1:0] hi;
        logic [FORCE_W-1:0] lo;
        div_op_t            o;
        hi = (l > r) ? l : r;
        lo = (l > r) ? r : l;
        o.skip     = (l < mn) || (r < mn) || (hi == '0);
        o.dividend = DIVD_W'(hi - lo) * DIVD_W'(ASYM_SCALE);
        o.divisor  = DSOR_W'(hi);
        return o;
    endfunction

    state_t state_reg, state_next;

    logic [OP_W-1:0]    op_reg, op_next;
    logic [FORCE_W-1:0] force_reg, force_next;
    logic               side_reg, side_next;
    logic [RAM_AW-1:0]  addr_reg, addr_next;

    logic [FILL_W-1:0]  fill_reg [2];
    logic [FILL_W-1:0]  fill_next [2];
    logic [POS_W-1:0]   pos_reg [2];
    logic [POS_W-1:0]   pos_next [2];
    logic [WSUM_W-1:0]  wsum_reg [2];
    logic [WSUM_W-1:0]  wsum_next [2];
    logic [CSUM_W-1:0]  csum_reg [2];
    logic [CSUM_W-1:0]  csum_next [2];
    logic [CCNT_W-1:0]  ccnt_reg [2];
    logic [CCNT_W-1:0]  ccnt_next [2];
    logic [FORCE_W-1:0] baseline_reg, baseline_next;

    logic [FORCE_W-1:0] lcal_reg, lcal_next;
    logic [FORCE_W-1:0] rcal_reg, rcal_next;
    logic [FORCE_W-1:0] lmean_reg, lmean_next;
    logic [FORCE_W-1:0] rmean_reg, rmean_next;
    logic [PCT_W-1:0]   asym_reg, asym_next;

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    div_t               div_reg, div_next;
    logic [DSOR_W-1:0]  dsor_reg, dsor_next;

    logic               out_valid_reg, out_valid_next;
    logic [FORCE_W-1:0] out_lavg_reg, out_lavg_next;
    logic [FORCE_W-1:0] out_ravg_reg, out_ravg_next;
    logic [PCT_W-1:0]   out_asym_reg, out_asym_next;
    logic [FORCE_W-1:0] out_thr_reg, out_thr_next;
    logic               out_done_reg, out_done_next;

    logic [FORCE_W-1:0] min_force_reg, min_force_next;
    logic [FORCE_W-1:0] alert_margin_reg, alert_margin_next;

    logic               ram_we;
    logic [RAM_AW-1:0]  ram_addr;
    logic [FORCE_W-1:0] ram_rdata;

    logic               in_side;
    logic [RAM_AW-1:0]  in_addr;
    logic               in_push;
    logic               calib_full;
    logic               in_full_after;
    logic               is_div;
    div_op_t            dop;
    div_t               div_two;
    logic               div_fin;
    logic [DIVD_W-1:0]  div_q;
    logic [FORCE_W:0]   thr_sum;
    logic [FORCE_W-1:0] thr_val;
    logic [FORCE_W-1:0] old_entry;

    gsat_ram #(
        .WIDTH (FORCE_W),
        .DEPTH (RAM_DEPTH)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (force_reg),
        .rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALERT_MARGIN) ? APB_DW'(alert_margin_reg)
                                                   : APB_DW'(min_force_reg);

    assign in_ch.ready              = (state_reg == S_IDLE);
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.left_average      = out_lavg_reg;
    assign out_ch.right_average     = out_ravg_reg;
    assign out_ch.asymmetry_percent = out_asym_reg;
    assign out_ch.alert_threshold   = out_thr_reg;
    assign out_ch.calibration_done  = out_done_reg;

    assign in_side = in_ch.is_left;
    assign in_addr = in_side ? RAM_AW'(WINDOW_STEPS) + RAM_AW'(pos_reg[1])
                             : RAM_AW'(pos_reg[0]);
    assign in_push = ((in_ch.opcode == OP_CALIB) &&
                      (ccnt_reg[in_side] != CCNT_W'(CALIB_STEPS))) ||
                     (in_ch.opcode == OP_RUN);
    assign calib_full = (ccnt_reg[1] == CCNT_W'(CALIB_STEPS)) &&
                        (ccnt_reg[0] == CCNT_W'(CALIB_STEPS));
    assign in_full_after =
        ((in_side || ccnt_reg[1] == CCNT_W'(CALIB_STEPS)) &&
         (ccnt_reg[1] >= CCNT_W'(CALIB_STEPS - 1))) &&
        ((!in_side || ccnt_reg[0] == CCNT_W'(CALIB_STEPS)) &&
         (ccnt_reg[0] >= CCNT_W'(CALIB_STEPS - 1)));

    assign is_div = (state_reg == S_BASE) || (state_reg == S_LMEAN) ||
                    (state_reg == S_RMEAN) || (state_reg == S_ASYM);

    assign div_two   = div_step(div_step(div_reg, dsor_reg), dsor_reg);
    assign thr_sum   = {1'b0, baseline_reg} + {1'b0, alert_margin_reg};
    assign thr_val   = calib_full ? (thr_sum[FORCE_W] ? '1 : thr_sum[FORCE_W-1:0])
                                  : alert_margin_reg;
    assign old_entry = (fill_reg[side_reg] == FILL_W'(WINDOW_STEPS)) ? ram_rdata : '0;

    always_comb
    begin
        dop = '0;
        unique case (state_reg)
            S_BASE:
            begin
                dop = asym_op(lcal_reg, rcal_reg, min_force_reg);
            end
            S_LMEAN:
            begin
                dop.skip     = (fill_reg[1] == '0);
                dop.dividend = DIVD_W'(wsum_reg[1]);
                dop.divisor  = DSOR_W'(fill_reg[1]);
            end
            S_RMEAN:
            begin
                dop.skip     = (fill_reg[0] == '0);
                dop.dividend = DIVD_W'(wsum_reg[0]);
                dop.divisor  = DSOR_W'(fill_reg[0]);
            end
            S_ASYM:
            begin
                dop = asym_op(lmean_reg, rmean_reg, min_force_reg);
            end
            default:
            begin
                dop = '0;
            end
        endcase
    end

    always_comb
    begin
        min_force_next    = min_force_reg;
        alert_margin_next = alert_margin_reg;
        if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_MIN_FORCE:    min_force_next    = pwdata[FORCE_W-1:0];
                REG_ALERT_MARGIN: alert_margin_next = pwdata[FORCE_W-1:0];
                default:          min_force_next    = min_force_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        force_next    = force_reg;
        side_next     = side_reg;
        addr_next     = addr_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        wsum_next     = wsum_reg;
        csum_next     = csum_reg;
        ccnt_next     = ccnt_reg;
        baseline_next = baseline_reg;
        lcal_next     = lcal_reg;
        rcal_next     = rcal_reg;
        lmean_next    = lmean_reg;
        rmean_next    = rmean_reg;
        asym_next     = asym_reg;
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        div_next      = div_reg;
        dsor_next     = dsor_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_lavg_next = out_lavg_reg;
        out_ravg_next = out_ravg_reg;
        out_asym_next = out_asym_reg;
        out_thr_next  = out_thr_reg;
        out_done_next = out_done_reg;
        ram_we        = 1'b0;
        ram_addr      = addr_reg;
        div_fin       = 1'b0;
        div_q         = '0;

        if (is_div)
        begin
            if (!busy_reg)
            begin
                if (dop.skip)
                begin
                    div_fin = 1'b1;
                end
                else
                begin
                    div_next.rem = '0;
                    div_next.quo = dop.dividend;
                    dsor_next    = dop.divisor;
                    cnt_next     = CNT_W'(DIV_CYC - 1);
                    busy_next    = 1'b1;
                end
            end
            else
            begin
                div_next = div_two;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    div_fin   = 1'b1;
                    div_q     = div_two.quo;
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                ram_addr = in_addr;
                if (in_ch.valid)
                begin
                    op_next    = in_ch.opcode;
                    force_next = in_ch.step_force;
                    side_next  = in_side;
                    addr_next  = in_addr;
                    if (in_ch.opcode == OP_RESTART)
                    begin
                        for (int s = 0; s < 2; s++)
                        begin
                            fill_next[s] = '0;
                            pos_next[s]  = '0;
                            wsum_next[s] = '0;
                            csum_next[s] = '0;
                            ccnt_next[s] = '0;
                        end
                        baseline_next = '0;
                        state_next    = S_LMEAN;
                    end
                    else if (in_push)
                    begin
                        if (in_ch.opcode == OP_CALIB)
                        begin
                            csum_next[in_side] = csum_reg[in_side] +
                                                 CSUM_W'(in_ch.step_force);
                            ccnt_next[in_side] = ccnt_reg[in_side] + 1'b1;
                        end
                        state_next = S_WRITE;
                    end
                    else if ((in_ch.opcode == OP_CALIB) && in_full_after)
                    begin
                        state_next = S_LCAL;
                    end
                    else
                    begin
                        state_next = S_LMEAN;
                    end
                end
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
                wsum_next[side_reg] = wsum_reg[side_reg] - WSUM_W'(old_entry) +
                                      WSUM_W'(force_reg);
                pos_next[side_reg]  = (pos_reg[side_reg] == POS_W'(WINDOW_STEPS - 1))
                                      ? '0 : pos_reg[side_reg] + 1'b1;
                if (fill_reg[side_reg] != FILL_W'(WINDOW_STEPS))
                begin
                    fill_next[side_reg] = fill_reg[side_reg] + 1'b1;
                end
                state_next = ((op_reg == OP_CALIB) && calib_full) ? S_LCAL : S_LMEAN;
            end
            S_LCAL:
            begin
                lcal_next  = FORCE_W'(csum_reg[1] / CSUM_W'(CALIB_STEPS));
                state_next = S_RCAL;
            end
            S_RCAL:
            begin
                rcal_next  = FORCE_W'(csum_reg[0] / CSUM_W'(CALIB_STEPS));
                state_next = S_BASE;
            end
            S_BASE:
            begin
                if (div_fin)
                begin
                    baseline_next = div_q[FORCE_W-1:0];
                    state_next    = S_LMEAN;
                end
            end
            S_LMEAN:
            begin
                if (div_fin)
                begin
                    lmean_next = div_q[FORCE_W-1:0];
                    state_next = S_RMEAN;
                end
            end
            S_RMEAN:
            begin
                if (div_fin)
                begin
                    rmean_next = div_q[FORCE_W-1:0];
                    state_next = S_ASYM;
                end
            end
            S_ASYM:
            begin
                if (div_fin)
                begin
                    asym_next  = div_q[PCT_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_lavg_next  = lmean_reg;
                    out_ravg_next  = rmean_reg;
                    out_asym_next  = asym_reg;
                    out_thr_next   = thr_val;
                    out_done_next  = calib_full;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            baseline_reg     <= '0;
            min_force_reg    <= MIN_FORCE_RST;
            alert_margin_reg <= ALERT_MARGIN_RST;
            for (int s = 0; s < 2; s++)
            begin
                fill_reg[s] <= '0;
                pos_reg[s]  <= '0;
                wsum_reg[s] <= '0;
                csum_reg[s] <= '0;
                ccnt_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            busy_reg         <= busy_next;
            out_valid_reg    <= out_valid_next;
            baseline_reg     <= baseline_next;
            min_force_reg    <= min_force_next;
            alert_margin_reg <= alert_margin_next;
            fill_reg         <= fill_next;
            pos_reg          <= pos_next;
            wsum_reg         <= wsum_next;
            csum_reg         <= csum_next;
            ccnt_reg         <= ccnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        force_reg    <= force_next;
        side_reg     <= side_next;
        addr_reg     <= addr_next;
        lcal_reg     <= lcal_next;
        rcal_reg     <= rcal_next;
        lmean_reg    <= lmean_next;
        rmean_reg    <= rmean_next;
        asym_reg     <= asym_next;
        cnt_reg      <= cnt_next;
        div_reg      <= div_next;
        dsor_reg     <= dsor_next;
        out_lavg_reg <= out_lavg_next;
        out_ravg_reg <= out_ravg_next;
        out_asym_reg <= out_asym_next;
        out_thr_reg  <= out_thr_next;
        out_done_reg <= out_done_next;
    end

endmodule

[design/gsat_checker.sv]
// Port-level assertions for the gait step asymmetry tracker and their bind.
module gsat_checker
    import gsat_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [PCT_W-1:0]   asymmetry_percent,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic               pready,
    input logic [APB_AW-1:0]  paddr,
    input logic [APB_DW-1:0]  pwdata,
    input logic [APB_DW-1:0]  prdata
);

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(asymmetry_percent))
        else $error("result transaction dropped or changed while stalled");

    a_one_step : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("step accepted while previous step still in progress");

    a_asym_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> asymmetry_percent <= PCT_W'(ASYM_SCALE))
        else $error("asymmetry percent above full scale");

    a_cfg_readback : assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=>
            (paddr[2] != $past(paddr[2])) ||
            (prdata[FORCE_W-1:0] == $past(pwdata[FORCE_W-1:0])))
        else $error("register readback differs from last write");

endmodule

bind gait_step_asymmetry_tracker gsat_checker u_gsat_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .asymmetry_percent (out_ch.asymmetry_percent),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata)
);
